/* sv/slr_pkg.sv */
package slr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int IN_RATE_W   = 19;
  localparam int OUT_RATE_W  = 16;
  localparam int PHASE_W     = 20;
  localparam int PH_W        = 21;
  localparam int FRAC_W      = 16;
  localparam int CNT_W       = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 19;
  localparam int PROD_W      = 34;

  localparam logic [CNT_W-1:0] MAX_RESULTS = CNT_W'(14);

  localparam logic [CFG_ADDR_W-1:0] REG_IN_RATE  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_RATE = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_MONO     = CFG_ADDR_W'(2);

  localparam logic [IN_RATE_W-1:0]  IN_RATE_RST  = IN_RATE_W'(48000);
  localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST = OUT_RATE_W'(48000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_HELD,
    S_LOOP,
    S_DIV,
    S_MUL,
    S_BLEND,
    S_POST,
    S_TAIL,
    S_FINISH
  } slr_state_t;

  typedef enum logic [1:0] {
    EMIT_CUR,
    EMIT_HELD,
    EMIT_BLEND
  } slr_emit_sel_t;

  typedef struct packed {
    logic          load;
    logic          ph_zero;
    logic          ph_from_rem;
    logic          clr_held;
    logic          div_start;
    logic          div_step;
    logic          mul;
    logic          hold_blend;
    logic          ph_add_ir;
    logic          ph_sub_or;
    logic          upd_prev;
    logic          save_phase;
    logic          clr_chunk;
    logic          emit;
    slr_emit_sel_t emit_sel;
    logic          flush;
  } slr_cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic rate_eq;
    logic have_prev;
    logic held_valid;
    logic held_ok;
    logic loop_go;
    logic blend_emit;
    logic tail_go;
    logic chunk_end;
    logic div_last;
    logic emit_ready;
    logic pend_valid;
    logic can_push;
  } slr_status_t;

endpackage

/* sv/stereo_linear_resampler_top.sv */
// Channel  | Direction | Beat contents
// in_      | slave     | tdata: sample_a[15:0], sample_b[31:16]; tuser: silent; tlast: chunk_end
// out_     | master    | tdata: out_left[15:0], out_right[31:16]; tlast: last_of_run
// cfg_     | write     | cfg_addr 0 in_rate, 1 out_rate, 2 mono_input; cfg_wdata[18:0]
//
// One input beat is taken at a time. Equal rates pass each frame straight through. Otherwise
// each blend position waits for a radix-2 divider to form its blend fraction, and a chunk end
// may add repeated tail outputs.
// Reset is synchronous, active low, and restores the register defaults and a fresh chunk.
// A stalled output holds the next result, and the input waits until no result is pending.
module stereo_linear_resampler_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [slr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [slr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // sample_a, sample_b
  input  logic                           in_tuser,   // silent
  input  logic                           in_tlast,   // chunk_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // out_left, out_right
  output logic                           out_tlast   // last_of_run
);
  import slr_pkg::*;

  slr_cmd_t    cmd;
  slr_status_t st;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  slr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

/* sv/slr_div.sv */
module slr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         step,
  input  logic [slr_pkg::FRAC_W-1:0]   dividend,
  input  logic [slr_pkg::OUT_RATE_W-1:0] divisor,
  output logic [slr_pkg::FRAC_W-1:0]   quotient,
  output logic                         last
);
  import slr_pkg::*;

  // Computes (dividend << 16) / divisor, one quotient bit per step.
  // The dividend is below the divisor, so the remainder fits in 16 bits.
  logic [OUT_RATE_W-1:0] rem_r, rem_nxt;
  logic [FRAC_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [OUT_RATE_W:0]   shifted;
  logic                  bit_q;

  always_comb begin
    shifted = {rem_r, 1'b0};
    bit_q   = (shifted >= {1'b0, divisor});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = dividend;
      quo_nxt = '0;
      cnt_nxt = '0;
    end else if (step) begin
      rem_nxt = bit_q ? OUT_RATE_W'(shifted - {1'b0, divisor}) : shifted[OUT_RATE_W-1:0];
      quo_nxt = {quo_r[FRAC_W-2:0], bit_q};
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quotient = quo_r;
  assign last     = step && (cnt_r == {CNT_W{1'b1}});

endmodule

/* sv/slr_datapath.sv */
module slr_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [slr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [slr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [2*slr_pkg::SAMPLE_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2*slr_pkg::SAMPLE_W-1:0]   out_tdata,
  output logic                             out_tlast,
  input  slr_pkg::slr_cmd_t                cmd,
  output slr_pkg::slr_status_t             st
);
  import slr_pkg::*;

  // Configuration.
  logic [IN_RATE_W-1:0]  in_rate_r;
  logic [OUT_RATE_W-1:0] out_rate_r;
  logic                  mono_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rate_r  <= IN_RATE_RST;
      out_rate_r <= OUT_RATE_RST;
      mono_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IN_RATE:  in_rate_r  <= cfg_wdata[IN_RATE_W-1:0];
        REG_OUT_RATE: out_rate_r <= cfg_wdata[OUT_RATE_W-1:0];
        REG_MONO:     mono_r     <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // Current frame.
  logic [SAMPLE_W-1:0] cur_l_r, cur_r_r, in_a, in_b;
  logic                end_r;

  assign in_a = in_tdata[SAMPLE_W-1:0];
  assign in_b = in_tdata[2*SAMPLE_W-1:SAMPLE_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_l_r <= in_tuser ? '0 : in_a;
      cur_r_r <= in_tuser ? '0 : (mono_r ? in_a : in_b);
      end_r   <= in_tlast;
    end
  end

  // Chunk state and the phase being worked on.
  logic [SAMPLE_W-1:0] prev_l_r, prev_r_r, held_l_r, held_r_r;
  logic                have_prev_r, held_valid_r;
  logic [PHASE_W-1:0]  phase_rem_r;
  logic [PH_W-1:0]     ph_r, ph_nxt;
  logic [PH_W:0]       ph_plus_ir;
  logic [OUT_RATE_W:0] two_orr;

  assign ph_plus_ir = {1'b0, ph_r} + (PH_W+1)'(in_rate_r);
  assign two_orr    = {out_rate_r, 1'b0};

  always_comb begin
    ph_nxt = ph_r;
    if (cmd.ph_zero) begin
      ph_nxt = '0;
    end else if (cmd.ph_from_rem) begin
      ph_nxt = {1'b0, phase_rem_r};
    end else if (cmd.ph_add_ir) begin
      ph_nxt = ph_plus_ir[PH_W-1:0];
    end else if (cmd.ph_sub_or) begin
      ph_nxt = ph_r - PH_W'(out_rate_r);
    end
  end

  always_ff @(posedge clk) begin
    ph_r <= ph_nxt;
  end

  // Blend fraction.
  logic [FRAC_W-1:0] frac;
  logic              div_last;

  slr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (ph_r[FRAC_W-1:0]),
    .divisor  (out_rate_r),
    .quotient (frac),
    .last     (div_last)
  );

  // One multiplier per channel, registered before the final add.
  logic signed [SAMPLE_W:0]   diff_l, diff_r;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [PROD_W-1:0]   prod_l_r, prod_r_r, t_l, t_r;
  logic [SAMPLE_W-1:0]        blend_l, blend_r;

  assign diff_l = $signed({cur_l_r[SAMPLE_W-1], cur_l_r}) - $signed({prev_l_r[SAMPLE_W-1], prev_l_r});
  assign diff_r = $signed({cur_r_r[SAMPLE_W-1], cur_r_r}) - $signed({prev_r_r[SAMPLE_W-1], prev_r_r});
  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l_r <= PROD_W'(diff_l * frac_s);
      prod_r_r <= PROD_W'(diff_r * frac_s);
    end
  end

  // Rounded, floored shift; the low 16 bits of the sum are all that survive.
  assign t_l     = prod_l_r + PROD_W'(32768);
  assign t_r     = prod_r_r + PROD_W'(32768);
  assign blend_l = prev_l_r + t_l[31:16];
  assign blend_r = prev_r_r + t_r[31:16];

  always_ff @(posedge clk) begin
    if (cmd.upd_prev) begin
      prev_l_r <= cur_l_r;
      prev_r_r <= cur_r_r;
    end
    if (cmd.hold_blend) begin
      held_l_r <= blend_l;
      held_r_r <= blend_r;
    end
    if (!rst_n) begin
      prev_l_r <= '0;
      prev_r_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      held_valid_r <= 1'b0;
      phase_rem_r  <= '0;
    end else begin
      if (cmd.clr_chunk) begin
        have_prev_r  <= 1'b0;
        held_valid_r <= 1'b0;
        phase_rem_r  <= '0;
      end else begin
        if (cmd.ph_zero) begin
          have_prev_r  <= 1'b1;
          held_valid_r <= 1'b0;
        end else if (cmd.clr_held) begin
          held_valid_r <= 1'b0;
        end else if (cmd.hold_blend) begin
          held_valid_r <= 1'b1;
        end
        if (cmd.save_phase) begin
          phase_rem_r <= ph_r[PHASE_W-1:0];
        end
      end
    end
  end

  // Results: one pending result waits until it is known whether another
  // follows, then moves to the output register.
  logic [2*SAMPLE_W-1:0] emit_data, pend_r, out_data_r;
  logic                  pend_valid_r, out_valid_r, out_last_r;
  logic [CNT_W-1:0]      n_r;
  logic                  can_push, emit_take, push;

  always_comb begin
    case (cmd.emit_sel)
      EMIT_HELD:  emit_data = {held_r_r, held_l_r};
      EMIT_BLEND: emit_data = {blend_r, blend_l};
      default:    emit_data = {cur_r_r, cur_l_r};
    endcase
  end

  assign can_push  = !out_valid_r || out_tready;
  assign emit_take = cmd.emit && (n_r != MAX_RESULTS);
  assign push      = (emit_take && pend_valid_r) || (cmd.flush && pend_valid_r);

  always_ff @(posedge clk) begin
    if (emit_take) begin
      pend_r <= emit_data;
    end
    if (push) begin
      out_data_r <= pend_r;
      out_last_r <= cmd.flush;
    end
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      n_r          <= '0;
    end else begin
      if (cmd.load) begin
        n_r <= '0;
      end else if (emit_take) begin
        n_r <= n_r + CNT_W'(1);
      end
      if (emit_take) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    st.rate_zero  = (in_rate_r == '0) || (out_rate_r == '0);
    st.rate_eq    = (in_rate_r == IN_RATE_W'(out_rate_r));
    st.have_prev  = have_prev_r;
    st.held_valid = held_valid_r;
    st.held_ok    = (ph_r <= PH_W'(two_orr));
    st.loop_go    = (ph_r < PH_W'(out_rate_r));
    st.blend_emit = (ph_plus_ir <= (PH_W+1)'(two_orr));
    st.tail_go    = (ph_plus_ir <= (PH_W+1)'(out_rate_r));
    st.chunk_end  = end_r;
    st.div_last   = div_last;
    st.emit_ready = (n_r == MAX_RESULTS) || !pend_valid_r || can_push;
    st.pend_valid = pend_valid_r;
    st.can_push   = can_push;
  end

  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (n_r != '0))
    else $error("pending result without a counted emit");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= MAX_RESULTS)
    else $error("result count beyond limit");

  a_held_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> have_prev_r)
    else $error("held result outside a chunk");

endmodule

/* sv/slr_ctrl.sv */
module slr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  slr_pkg::slr_status_t  st,
  output slr_pkg::slr_cmd_t     cmd
);
  import slr_pkg::*;

  slr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_sel = EMIT_CUR;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.rate_zero) begin
          state_nxt = S_IDLE;
        end else if (st.rate_eq) begin
          if (st.emit_ready) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_CUR;
            cmd.upd_prev  = 1'b1;
            cmd.clr_chunk = 1'b1;
            state_nxt     = S_FINISH;
          end
        end else if (!st.have_prev) begin
          cmd.ph_zero = 1'b1;
          state_nxt   = S_POST;
        end else begin
          cmd.ph_from_rem = 1'b1;
          state_nxt       = S_HELD;
        end
      end
      S_HELD: begin
        // A held-back result is confirmed once the phase shows the chunk
        // reached far enough; a chunk end drops it otherwise.
        if (st.held_valid && st.held_ok) begin
          if (st.emit_ready) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_HELD;
            cmd.clr_held = 1'b1;
            state_nxt    = S_LOOP;
          end
        end else begin
          cmd.clr_held = st.held_valid && st.chunk_end;
          state_nxt    = S_LOOP;
        end
      end
      S_LOOP: begin
        if (st.loop_go) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.ph_sub_or = 1'b1;
          state_nxt     = S_POST;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_BLEND;
      end
      S_BLEND: begin
        if (st.blend_emit) begin
          if (st.emit_ready) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_BLEND;
            cmd.ph_add_ir = 1'b1;
            state_nxt     = S_LOOP;
          end
        end else begin
          cmd.hold_blend = !st.chunk_end;
          cmd.ph_add_ir  = 1'b1;
          state_nxt      = S_LOOP;
        end
      end
      S_POST: begin
        cmd.upd_prev = 1'b1;
        if (st.chunk_end) begin
          state_nxt = S_TAIL;
        end else begin
          cmd.save_phase = 1'b1;
          state_nxt      = S_FINISH;
        end
      end
      S_TAIL: begin
        // Past the last frame of the chunk, that frame is repeated.
        if (st.tail_go) begin
          if (st.emit_ready) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_CUR;
            cmd.ph_add_ir = 1'b1;
          end
        end else begin
          cmd.clr_chunk = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (st.can_push) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !st.pend_valid)
    else $error("idle with an undelivered result");

  a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> ($past(state_r) == S_DIV) && $past(st.div_last))
    else $error("multiply without a finished fraction");

endmodule
